@@ sv/fita_pkg.sv @@
// ============================================================================
// fita_pkg
// Types, constants and the control program of the integer-to-ascii converter
// ============================================================================
package fita_pkg;

    // digit store depth: eleven octal digits of a 32-bit value
    localparam int MAX_DIGITS = 11;
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // conversion request codes
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEX  = 3'd3;
    localparam logic [2:0] OP_CHAR = 3'd4;

    // ascii constants
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ALPHA = 8'h37; // 'A' - 10

    // reciprocal of ten: floor(x / 10) = (x * RECIP10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // program steps
    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE  = 3'd0;
    localparam step_t ST_MUL   = 3'd1;
    localparam step_t ST_DIGD  = 3'd2;
    localparam step_t ST_SETUP = 3'd3;
    localparam step_t ST_EMIT  = 3'd4;
    localparam step_t ST_DIGS  = 3'd5;
    localparam step_t ST_BACK  = 3'd6;
    localparam step_t ST_CHAR  = 3'd7;

    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_MUL,
        A_DIGIT,
        A_SETUP,
        A_EMIT,
        A_CHAR
    } act_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_LOOP,
        C_EMPTY,
        C_EMIT
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t jmp;
    } uword_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic       in_valid;
        logic [2:0] opcode;
        logic       loop_more;
        logic       empty;
        logic       emit_done;
    } seq_stat_t;

    // control store
    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            ST_IDLE:  w = '{act: A_LOAD,  cond: C_DISPATCH, jmp: ST_IDLE};
            ST_MUL:   w = '{act: A_MUL,   cond: C_NEXT,     jmp: ST_IDLE};
            ST_DIGD:  w = '{act: A_DIGIT, cond: C_LOOP,     jmp: ST_MUL};
            ST_SETUP: w = '{act: A_SETUP, cond: C_EMPTY,    jmp: ST_IDLE};
            ST_EMIT:  w = '{act: A_EMIT,  cond: C_EMIT,     jmp: ST_IDLE};
            ST_DIGS:  w = '{act: A_DIGIT, cond: C_LOOP,     jmp: ST_DIGS};
            ST_BACK:  w = '{act: A_NONE,  cond: C_JUMP,     jmp: ST_SETUP};
            ST_CHAR:  w = '{act: A_CHAR,  cond: C_EMIT,     jmp: ST_IDLE};
            default:  w = '{act: A_NONE,  cond: C_JUMP,     jmp: ST_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {4'b0, d};
        else
            c = CH_ALPHA + {4'b0, d};
        return c;
    endfunction

endpackage

@@ sv/fita_seq.sv @@
// ============================================================================
// fita_seq
// Step counter and control store of the integer-to-ascii converter
// ============================================================================
module fita_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  fita_pkg::seq_stat_t stat,
    output fita_pkg::uword_t   ctrl
);
    import fita_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    step_t dispatch;

    assign ctrl = ucode(pc_reg);

    always_comb
    begin
        case (stat.opcode) inside
            OP_SDEC, OP_UDEC: dispatch = ST_MUL;
            OP_OCT, OP_HEX:   dispatch = ST_DIGS;
            OP_CHAR:          dispatch = ST_CHAR;
            default:          dispatch = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.cond)
            C_NEXT:     pc_next = pc_reg + 3'd1;
            C_JUMP:     pc_next = ctrl.jmp;
            C_DISPATCH: pc_next = stat.in_valid ? dispatch : pc_reg;
            C_LOOP:     pc_next = stat.loop_more ? ctrl.jmp : pc_reg + 3'd1;
            C_EMPTY:    pc_next = stat.empty ? ctrl.jmp : pc_reg + 3'd1;
            C_EMIT:     pc_next = stat.emit_done ? ctrl.jmp : pc_reg;
            default:    pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ST_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ sv/formatted_integer_to_ascii.sv @@
// ============================================================================
// formatted_integer_to_ascii
// printf-style integer conversion with width, precision and padding
// ============================================================================
// usage
// - input channel: one item is a 32-bit value plus a conversion request
//   (signed/unsigned decimal, octal, upper hex or single character) and the
//   width/precision/flag fields; accepted when in_valid is high and in_stall
//   is low. in_stall is high whenever a conversion is in progress.
// - output channel: one item per ascii character, last marks the final one;
//   taken when out_valid is high and out_stall is low.
// - sequencing: a microcoded sequencer runs each item. each decimal digit
//   takes a reciprocal multiply step, then a digit and remainder step;
//   octal and hex digits take a digit step each and then a return step.
//   a setup step follows, then one character per cycle while the receiver
//   does not stall. a character item goes from idle to its character step.
// - items with an unknown request code, or with zero precision and no
//   padding, are consumed and produce no output.
// - when the receiver stalls, the output register holds and the sequencer
//   waits in its emit or character step; nothing is dropped.
// - reset returns the sequencer to idle and empties the output register.
// ============================================================================
module formatted_integer_to_ascii (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] value,
    input  logic        zero_pad,
    input  logic        left_adjust,
    input  logic        width_valid,
    input  logic [5:0]  field_width,
    input  logic        prec_valid,
    input  logic [5:0]  precision,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last
);
    import fita_pkg::*;

    // sequencer
    uword_t    ctrl;
    seq_stat_t stat;

    // request registers
    logic        dec_reg, dec_next;
    logic        hex_reg, hex_next;
    logic        neg_reg, neg_next;
    logic        zp_reg, zp_next;
    logic        la_reg, la_next;
    logic        wv_reg, wv_next;
    logic [5:0]  fw_reg, fw_next;
    logic        pv_reg, pv_next;
    logic [5:0]  pr_reg, pr_next;

    // digit datapath
    logic [31:0] mag_reg, mag_next;
    logic [63:0] prod_reg, prod_next;
    logic [7:0]  store_reg [MAX_DIGITS];
    logic        store_we;
    logic [7:0]  store_wdata;
    logic [IDX_W-1:0] ndig_reg, ndig_next;

    // emit counters
    logic [3:0]  text_left_reg, text_left_next;
    logic [5:0]  pad_left_reg, pad_left_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        last_reg, last_next;

    // combinational helpers
    logic [31:0] quot;
    logic [31:0] rem;
    logic [3:0]  digit;
    logic [31:0] mag_step;
    logic [IDX_W-1:0] len_raw;
    logic [IDX_W-1:0] len;
    logic [5:0]  pad;
    logic [6:0]  total_left;
    logic        take_text;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]  text_ch;
    logic [7:0]  pad_ch;
    logic [7:0]  emit_ch;
    logic        out_free;
    logic        emit_fire;
    logic        emit_final;
    logic        accept;

    fita_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign in_stall  = (ctrl.act != A_LOAD);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    // divide by ten through the registered reciprocal product
    assign quot = 32'(prod_reg[63:RECIP_SHIFT]);
    assign rem  = mag_reg - (quot << 3) - (quot << 1);

    always_comb
    begin
        if (dec_reg)
        begin
            digit    = rem[3:0];
            mag_step = quot;
        end
        else if (hex_reg)
        begin
            digit    = mag_reg[3:0];
            mag_step = mag_reg >> 4;
        end
        else
        begin
            digit    = {1'b0, mag_reg[2:0]};
            mag_step = mag_reg >> 3;
        end
    end

    // text length after precision, pad count after width
    assign len_raw = ndig_reg + IDX_W'(neg_reg);
    assign len     = (pv_reg && pr_reg < 6'(len_raw)) ? pr_reg[IDX_W-1:0] : len_raw;
    assign pad     = (wv_reg && fw_reg > 6'(len)) ? fw_reg - 6'(len) : 6'd0;

    // character selection while emitting
    assign total_left = 7'(text_left_reg) + 7'(pad_left_reg);
    assign take_text  = la_reg ? (text_left_reg != 4'd0) : (pad_left_reg == 6'd0);
    // digits sit least significant first; text position 0 is the sign if any
    assign rd_idx     = ndig_reg + IDX_W'(neg_reg) - IDX_W'(1) - pos_reg;
    assign text_ch    = (neg_reg && pos_reg == '0) ? CH_MINUS : store_reg[rd_idx];
    assign pad_ch     = (la_reg || neg_reg || !zp_reg) ? CH_SPACE : CH_ZERO;
    assign emit_ch    = (ctrl.act == A_CHAR) ? mag_reg[7:0]
                      : (take_text ? text_ch : pad_ch);

    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_fire  = (ctrl.act == A_EMIT || ctrl.act == A_CHAR) && out_free;
    assign emit_final = (ctrl.act == A_CHAR) || (total_left == 7'd1);

    always_comb
    begin
        stat.in_valid  = in_valid;
        stat.opcode    = opcode;
        stat.loop_more = (mag_step != 32'd0);
        stat.empty     = (len == '0) && (pad == 6'd0);
        stat.emit_done = emit_fire && emit_final;
    end

    // datapath next state, decoded from the control word
    always_comb
    begin
        dec_next       = dec_reg;
        hex_next       = hex_reg;
        neg_next       = neg_reg;
        zp_next        = zp_reg;
        la_next        = la_reg;
        wv_next        = wv_reg;
        fw_next        = fw_reg;
        pv_next        = pv_reg;
        pr_next        = pr_reg;
        mag_next       = mag_reg;
        prod_next      = prod_reg;
        ndig_next      = ndig_reg;
        text_left_next = text_left_reg;
        pad_left_next  = pad_left_reg;
        pos_next       = pos_reg;
        store_we       = 1'b0;
        store_wdata    = digit_char(digit);

        unique case (ctrl.act)
            A_LOAD:
            begin
                if (accept)
                begin
                    dec_next  = (opcode == OP_SDEC) || (opcode == OP_UDEC);
                    hex_next  = (opcode == OP_HEX);
                    neg_next  = (opcode == OP_SDEC) && value[31];
                    mag_next  = ((opcode == OP_SDEC) && value[31]) ? 32'd0 - value : value;
                    zp_next   = zero_pad;
                    la_next   = left_adjust;
                    wv_next   = width_valid;
                    fw_next   = field_width;
                    pv_next   = prec_valid;
                    pr_next   = precision;
                    ndig_next = '0;
                end
            end
            A_MUL:
            begin
                prod_next = mag_reg * RECIP10;
            end
            A_DIGIT:
            begin
                store_we  = 1'b1;
                mag_next  = mag_step;
                ndig_next = ndig_reg + IDX_W'(1);
            end
            A_SETUP:
            begin
                text_left_next = 4'(len);
                pad_left_next  = pad;
                pos_next       = '0;
            end
            A_EMIT:
            begin
                if (emit_fire)
                begin
                    if (take_text)
                    begin
                        text_left_next = text_left_reg - 4'd1;
                        pos_next       = pos_reg + IDX_W'(1);
                    end
                    else
                    begin
                        pad_left_next = pad_left_reg - 6'd1;
                    end
                end
            end
            A_CHAR, A_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register: refilled in the same cycle it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_ch;
            last_next      = emit_final;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ndig_reg      <= '0;
            text_left_reg <= 4'd0;
            pad_left_reg  <= 6'd0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            ndig_reg      <= ndig_next;
            text_left_reg <= text_left_next;
            pad_left_reg  <= pad_left_next;
            pos_reg       <= pos_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dec_reg      <= dec_next;
        hex_reg      <= hex_next;
        neg_reg      <= neg_next;
        zp_reg       <= zp_next;
        la_reg       <= la_next;
        wv_reg       <= wv_next;
        fw_reg       <= fw_next;
        pv_reg       <= pv_next;
        pr_reg       <= pr_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        if (store_we)
            store_reg[ndig_reg] <= store_wdata;
    end

`ifndef SYNTHESIS
    // emitting with nothing left to send means the counters slipped
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == A_EMIT) |-> (total_left != 7'd0))
        else $error("emit step with empty counters");

    // the digit count never exceeds the store depth
    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ndig_reg <= IDX_W'(MAX_DIGITS)))
        else $error("digit count beyond store depth");

    // a digit read always lands on a written entry
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && ctrl.act == A_EMIT && take_text && !(neg_reg && pos_reg == '0))
        |-> (rd_idx < ndig_reg))
        else $error("digit read outside written range");

    // the final character returns the block to accepting input
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_final) |=> (ctrl.act == A_LOAD))
        else $error("sequencer not idle after final character");
`endif

endmodule
